// ===== src/rar_pkg.sv =====
// Shared types and constants for the rational arithmetic/reduction block.
// No dependencies; used by rar_ctrl, rar_dp and rational_arith_reduce_top.
`default_nettype none
package rar_pkg;
    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_NEG = 3'd4,
        CMD_EQ  = 3'd5
    } cmd_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture operands
        logic mul;      // form products
        logic comb;     // combine into exact n/d
        logic gstep;    // one gcd step
        logic dstart;   // prepare divisions
        logic dstep;    // one division step
        logic fin;      // finish result
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic skip;     // no reduction needed
        logic gdone;    // gcd finished
        logic ddone;    // divisions finished
    } ctrl_sts_t;
endpackage
`default_nettype wire

// ===== src/rar_dp.sv =====
// Datapath: operand products, binary gcd and two restoring divisions.
// Depends on rar_pkg.
`default_nettype none
module rar_dp #(
    parameter int OperandWidth = 16
) (
    input  wire                logic            aclk,
    input  wire                logic [2:0]      cmd,
    input  wire                logic [OperandWidth-1:0] a_num,
    input  wire                logic [OperandWidth-1:0] a_den,
    input  wire                logic [OperandWidth-1:0] b_num,
    input  wire                logic [OperandWidth-1:0] b_den,
    input  wire                rar_pkg::ctrl_cmd_t ctl,
    output rar_pkg::ctrl_sts_t sts,
    output logic [31:0]        res_num,
    output logic [30:0]        res_den,
    output logic               is_equal,
    output logic               div_zero,
    output logic               overflow
);
    import rar_pkg::*;
    localparam int W  = OperandWidth;
    localparam int PW = 2 * W + 2;   // exact numerator/denominator width
    localparam int MW = PW - 1;      // magnitude width
    localparam int CW = $clog2(MW + 1);

    logic [2:0] cmd_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg;
    logic [MW-1:0] nm_reg, dm_reg;   // magnitudes
    logic          neg_reg, eq_reg, zero_reg;
    logic [MW-1:0] gx_reg, gy_reg;
    logic [CW-1:0] gk_reg;
    logic [MW-1:0] g_reg, qn_reg, qd_reg, rn_reg, rd_reg, dn_reg, dd_reg;
    logic [CW-1:0] dc_reg;

    logic signed [PW-1:0] ext_an, ext_ad, ext_bn, ext_bd, nn, dd;
    assign ext_an = PW'(an_reg);
    assign ext_ad = PW'(ad_reg);
    assign ext_bn = PW'(bn_reg);
    assign ext_bd = PW'(bd_reg);

    // operand-width products, widened afterwards
    logic signed [2*W-1:0] pr1, pr2, pr3;
    assign pr1 = an_reg * ((cmd_reg == CMD_MUL) ? bn_reg : bd_reg);
    assign pr2 = ad_reg * bn_reg;
    assign pr3 = ad_reg * bd_reg;

    // wide views of the quotients for range checks
    logic [63:0] qn_w, qd_w;
    assign qn_w = 64'(qn_reg);
    assign qd_w = 64'(qd_reg);

    always_comb begin
        nn = '0;
        dd = PW'(1);
        case (cmd_reg)
            CMD_ADD: begin
                nn = (ad_reg == bd_reg) ? ext_an + ext_bn : p1_reg + p2_reg;
                dd = (ad_reg == bd_reg) ? ext_ad : p3_reg;
            end
            CMD_SUB: begin
                nn = (ad_reg == bd_reg) ? ext_an - ext_bn : p1_reg - p2_reg;
                dd = (ad_reg == bd_reg) ? ext_ad : p3_reg;
            end
            CMD_MUL: begin
                nn = p1_reg;
                dd = p3_reg;
            end
            CMD_DIV: begin
                nn = p1_reg;
                dd = p2_reg;
            end
            CMD_NEG: begin
                nn = -ext_an;
                dd = ext_ad;
            end
            default: ;
        endcase
    end

    // restoring division step helpers
    logic [MW:0] trn, trd;
    assign trn = {rn_reg, dn_reg[MW-1]} - {1'b0, g_reg};
    assign trd = {rd_reg, dd_reg[MW-1]} - {1'b0, g_reg};

    logic eqv;
    always_comb begin
        if (ad_reg != '0 && bd_reg != '0)
            eqv = (p1_reg == p2_reg);
        else if (ad_reg == '0 && bd_reg == '0)
            eqv = (an_reg != '0) && (an_reg[W-1] == bn_reg[W-1]) && (bn_reg != '0);
        else
            eqv = 1'b0;
    end

    logic [MW-1:0] gmin, gmax, gdif;
    assign gmin = (gx_reg < gy_reg) ? gx_reg : gy_reg;
    assign gmax = (gx_reg < gy_reg) ? gy_reg : gx_reg;
    assign gdif = gmax - gmin;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg <= cmd;
            an_reg  <= a_num;
            ad_reg  <= a_den;
            bn_reg  <= b_num;
            bd_reg  <= b_den;
        end
        if (ctl.mul) begin
            // p1 = an*bd (or an*bn), p2 = ad*bn (or bn*ad), p3 = ad*bd
            p1_reg <= PW'(pr1);
            p2_reg <= PW'(pr2);
            p3_reg <= PW'(pr3);
        end
        if (ctl.comb) begin
            eq_reg   <= (cmd_reg == CMD_EQ) && eqv;
            zero_reg <= (nn == '0) || cmd_reg > CMD_NEG;
            neg_reg  <= nn[PW-1] ^ dd[PW-1];
            nm_reg   <= nn[PW-1] ? MW'(-nn) : MW'(nn);
            dm_reg   <= dd[PW-1] ? MW'(-dd) : MW'(dd);
            gx_reg   <= nn[PW-1] ? MW'(-nn) : MW'(nn);
            gy_reg   <= dd[PW-1] ? MW'(-dd) : MW'(dd);
            gk_reg   <= '0;
        end
        if (ctl.gstep) begin
            // Stein: strip shared twos, then subtract
            if (gy_reg == '0) begin
                g_reg <= gx_reg << gk_reg;
            end else if (!gx_reg[0] && !gy_reg[0]) begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + 1'b1;
            end else if (!gx_reg[0]) begin
                gx_reg <= gx_reg >> 1;
            end else if (!gy_reg[0]) begin
                gy_reg <= gy_reg >> 1;
            end else begin
                gx_reg <= gmin;
                gy_reg <= gdif;
            end
        end
        if (ctl.dstart) begin
            dn_reg <= nm_reg;
            dd_reg <= dm_reg;
            rn_reg <= '0;
            rd_reg <= '0;
            qn_reg <= '0;
            qd_reg <= '0;
            dc_reg <= '0;
        end
        if (ctl.dstep) begin
            dn_reg <= dn_reg << 1;
            dd_reg <= dd_reg << 1;
            dc_reg <= dc_reg + 1'b1;
            if (!trn[MW]) begin
                rn_reg <= trn[MW-1:0];
                qn_reg <= {qn_reg[MW-2:0], 1'b1};
            end else begin
                rn_reg <= {rn_reg[MW-2:0], dn_reg[MW-1]};
                qn_reg <= {qn_reg[MW-2:0], 1'b0};
            end
            if (!trd[MW]) begin
                rd_reg <= trd[MW-1:0];
                qd_reg <= {qd_reg[MW-2:0], 1'b1};
            end else begin
                rd_reg <= {rd_reg[MW-2:0], dd_reg[MW-1]};
                qd_reg <= {qd_reg[MW-2:0], 1'b0};
            end
        end
        if (ctl.fin) begin
            is_equal <= eq_reg;
            if (zero_reg) begin
                res_num  <= 32'd0;
                res_den  <= 31'd1;
                div_zero <= 1'b0;
                overflow <= 1'b0;
            end else begin
                res_num  <= neg_reg ? 32'(-qn_w) : 32'(qn_w);
                res_den  <= 31'(qd_reg);
                div_zero <= (qd_reg == '0);
                overflow <= (qd_w > 64'h7FFF_FFFF) ||
                    (!neg_reg && qn_w > 64'h7FFF_FFFF) ||
                    (neg_reg && qn_w > 64'h8000_0000);
            end
        end
    end

    assign sts = '{skip: zero_reg, gdone: (gy_reg == '0), ddone: (dc_reg == CW'(MW))};
endmodule
`default_nettype wire

// ===== src/rar_ctrl.sv =====
// Controller: sequences load, products, gcd, divisions and result output.
// Depends on rar_pkg.
`default_nettype none
module rar_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire rar_pkg::ctrl_sts_t sts,
    output rar_pkg::ctrl_cmd_t      ctl
);
    import rar_pkg::*;
    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_COMB, ST_GCD, ST_GFIN, ST_DIV, ST_FIN
    } state_t;
    state_t state_reg;
    logic   out_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_reg;

    always_comb begin
        ctl        = '0;
        ctl.load   = s_tvalid && s_tready;
        ctl.mul    = (state_reg == ST_MUL);
        ctl.comb   = (state_reg == ST_COMB);
        ctl.gstep  = (state_reg == ST_GCD) || (state_reg == ST_GFIN);
        ctl.dstart = (state_reg == ST_GFIN);
        ctl.dstep  = (state_reg == ST_DIV) && !sts.ddone;
        ctl.fin    = (state_reg == ST_FIN) && (!out_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_reg   <= 1'b0;
        end else begin
            if (ctl.fin) out_reg <= 1'b1;
            else if (m_tready) out_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_tvalid) state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_COMB;
                ST_COMB: state_reg <= ST_GCD;
                ST_GCD: begin
                    if (sts.skip) state_reg <= ST_FIN;
                    else if (sts.gdone) state_reg <= ST_GFIN;
                end
                ST_GFIN: state_reg <= ST_DIV;
                ST_DIV:  if (sts.ddone) state_reg <= ST_FIN;
                ST_FIN: begin
                    if (ctl.fin) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && state_reg != ST_IDLE)) else $error("ready outside idle");
    a_fin_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fin |=> m_tvalid) else $error("result not presented");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ===== src/rational_arith_reduce_top.sv =====
// Top level of the rational arithmetic unit with reduction to lowest terms.
// Depends on rar_pkg, rar_ctrl and rar_dp.
`default_nettype none
// One transfer in gives one transfer out. An item passes through the product and
// combine steps, then a binary gcd loop over the (2W+1)-bit magnitudes that halves
// or subtracts once per step (at least one step, at most about two per bit of both
// magnitudes, near 8*W), then a division setup step and 2W+1 restoring division
// steps that divide numerator and denominator by the gcd side by side, and a final
// output step. A zero result, an equality test or an unused command skips gcd
// and division. Input is taken only while idle, so the next input is taken
// only after the result is registered; the result waits in an output register
// until taken, and a following item holds in its final state until that
// register is free.
module rational_arith_reduce_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // a_num[W-1:0], a_den, b_num, b_den from lowest bits up, zero padded
    input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic [2:0] s_tuser,  // cmd
    output logic      m_tvalid,
    input  wire logic m_tready,
    // res_num[31:0], res_den[62:32], is_equal[63], div_zero[64], overflow[65]
    output logic [71:0] m_tdata
);
    import rar_pkg::*;
    localparam int W = OPERAND_WIDTH;
    ctrl_cmd_t ctl;
    ctrl_sts_t sts;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic is_equal, div_zero, overflow;

    rar_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .ctl(ctl)
    );

    rar_dp #(.OperandWidth(W)) u_dp (
        .aclk(aclk), .cmd(s_tuser),
        .a_num(s_tdata[W-1:0]), .a_den(s_tdata[2*W-1:W]),
        .b_num(s_tdata[3*W-1:2*W]), .b_den(s_tdata[4*W-1:3*W]),
        .ctl(ctl), .sts(sts),
        .res_num(res_num), .res_den(res_den), .is_equal(is_equal),
        .div_zero(div_zero), .overflow(overflow)
    );

    assign m_tdata = {6'd0, overflow, div_zero, is_equal, res_den, res_num};
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for rational_arith_reduce_top: directed table, then random traffic.
// Depends on rar_pkg (cmd_t) and the RTL top; predicts a result from the operands unless the row gives one.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rar_pkg::*;

    typedef struct {
        logic [31:0] num;
        logic [30:0] den;
        logic        eq;
        logic        dz;
        logic        ovf;
    } ratio_res_t;

    typedef struct {
        logic [2:0]  cmd;
        shortint     an;
        shortint     ad;
        shortint     bn;
        shortint     bd;
        bit          typed;
        ratio_res_t  exp;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    ratio_res_t  pending_q[$];
    stim_row_t   dir_tab[$];
    int          n_fail = 0;
    int          n_sent = 0;
    int          n_got = 0;
    int          n_divz = 0;
    int          n_eq = 0;
    int          hold_cnt = 0;
    bit          hold_req = 0;
    bit          hold_used = 0;
    bit          calm = 0;
    int          idle_cycles = 0;

    always #5 aclk = ~aclk;

    rational_arith_reduce_top #(.OPERAND_WIDTH(16)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Bring n/d to lowest terms with the sign on the numerator.
    function automatic ratio_res_t reduce_frac(longint n, longint d);
        ratio_res_t      r;
        longint unsigned mag, g;
        r = '{num: 32'd0, den: 31'd1, eq: 1'b0, dz: 1'b0, ovf: 1'b0};
        if (n == 0) return r;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        mag = (n < 0) ? longint'(-n) : longint'(n);
        g = gcd_of(mag, d);
        if (g > 1) begin
            n = n / longint'(g);
            d = d / longint'(g);
        end
        r.num = n[31:0];
        r.den = d[30:0];
        r.dz  = (d == 0);
        r.ovf = (n < -64'sd2147483648) || (n > 64'sd2147483647) || (d > 64'sd2147483647);
        return r;
    endfunction

    function automatic ratio_res_t predict_ratio(logic [2:0] c, shortint an_s, shortint ad_s,
                                                 shortint bn_s, shortint bd_s);
        ratio_res_t r;
        longint     an, ad, bn, bd;
        an = an_s;
        ad = ad_s;
        bn = bn_s;
        bd = bd_s;
        r = '{num: 32'd0, den: 31'd1, eq: 1'b0, dz: 1'b0, ovf: 1'b0};
        case (c)
            CMD_ADD: r = (ad == bd) ? reduce_frac(an + bn, ad) : reduce_frac(an*bd + ad*bn, ad*bd);
            CMD_SUB: r = (ad == bd) ? reduce_frac(an - bn, ad) : reduce_frac(an*bd - ad*bn, ad*bd);
            CMD_MUL: r = reduce_frac(an * bn, ad * bd);
            CMD_DIV: r = reduce_frac(an * bd, ad * bn);
            CMD_NEG: r = reduce_frac(-an, ad);
            CMD_EQ: begin
                if (ad != 0 && bd != 0)
                    r.eq = (an * bd == bn * ad);
                else if (ad == 0 && bd == 0)
                    r.eq = (an != 0) && ((an > 0) == (bn > 0)) && (bn != 0);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic ratio_res_t res_of(int num, int den, bit eq, bit dz);
        ratio_res_t r;
        r = '{num: 32'(num), den: 31'(den), eq: eq, dz: dz, ovf: 1'b0};
        return r;
    endfunction

    function automatic shortint rand_opnd();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return shortint'($urandom);
            4, 5, 6:    return shortint'(int'($urandom_range(0, 16)) - 8);
            7:          return shortint'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff);
            8:          return shortint'($urandom_range(0, 1) ? 16'hffff : 16'h0001);
            default:    return shortint'(0);
        endcase
    endfunction

    // Offer one item and hold it until the transfer; then queue its expectation.
    task automatic send_item(stim_row_t row);
        s_tvalid <= 1'b1;
        s_tuser  <= row.cmd;
        s_tdata  <= {row.bd, row.bn, row.ad, row.an};
        do @(posedge aclk); while (!s_tready);
        pending_q.push_back(row.typed ? row.exp
                            : predict_ratio(row.cmd, row.an, row.ad, row.bn, row.bd));
        n_sent++;
        if (!calm && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Receiver: random backpressure, one long hold-off, a calm stretch with none.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_used) begin
            hold_used <= 1'b1;
            hold_cnt  <= 400;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        ratio_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_got++;
            if (pending_q.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                n_fail++;
            end else begin
                e = pending_q.pop_front();
                if (e.dz) n_divz++;
                if (e.eq) n_eq++;
                if (m_tdata[31:0] !== e.num) begin
                    $error("res_num exp %0d got %0d", $signed(e.num), $signed(m_tdata[31:0]));
                    n_fail++;
                end
                if (m_tdata[62:32] !== e.den) begin
                    $error("res_den exp %0d got %0d", e.den, m_tdata[62:32]);
                    n_fail++;
                end
                if (m_tdata[63] !== e.eq) begin
                    $error("is_equal exp %0b got %0b", e.eq, m_tdata[63]);
                    n_fail++;
                end
                if (m_tdata[64] !== e.dz) begin
                    $error("div_zero exp %0b got %0b", e.dz, m_tdata[64]);
                    n_fail++;
                end
                if (m_tdata[65] !== e.ovf) begin
                    $error("overflow exp %0b got %0b", e.ovf, m_tdata[65]);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: stop if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        stim_row_t row;
        dir_tab.push_back('{CMD_ADD, 1, 2, 1, 3, 0, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_ADD, 0, 5, 0, 5, 1, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_SUB, 3, 4, 3, 4, 1, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_SUB, -32768, 1, 32767, -1, 0, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_MUL, -32768, -32768, -32768, -32768, 1, res_of(1, 1, 0, 0)});
        dir_tab.push_back('{CMD_MUL, 32767, 1, 32767, 1, 0, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_DIV, 1, 2, 0, 3, 1, res_of(1, 0, 0, 1)});
        dir_tab.push_back('{CMD_DIV, -5, 1, 0, 7, 1, res_of(-1, 0, 0, 1)});
        dir_tab.push_back('{CMD_DIV, 0, 0, 1, 1, 1, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_NEG, -32768, 1, 0, 0, 1, res_of(32768, 1, 0, 0)});
        dir_tab.push_back('{CMD_NEG, 5, -10, 0, 0, 1, res_of(1, 2, 0, 0)});
        dir_tab.push_back('{CMD_EQ, 1, 2, 2, 4, 1, res_of(0, 1, 1, 0)});
        dir_tab.push_back('{CMD_EQ, 1, 0, 3, 0, 1, res_of(0, 1, 1, 0)});
        dir_tab.push_back('{CMD_EQ, 1, 0, -3, 0, 1, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_EQ, 0, 0, 0, 0, 1, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_EQ, 1, 2, 1, 0, 1, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{3'd6, 7, 3, 2, 5, 1, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{3'd7, -1, -1, -1, -1, 1, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_ADD, -32768, -32768, -32768, -32767, 0, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_ADD, 32767, -32768, 32767, 32767, 0, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_SUB, -1, -1, -1, -1, 0, res_of(0, 1, 0, 0)});
        dir_tab.push_back('{CMD_MUL, -32768, 32767, 32767, -32768, 0, res_of(0, 1, 0, 0)});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) send_item(dir_tab[i]);

        for (int k = 0; k < 750; k++) begin
            calm     = (k >= 300 && k < 400);
            hold_req = (k >= 150);
            // Pause once until the pipeline has drained completely.
            if (k == 500) begin
                s_tvalid <= 1'b0;
                while (pending_q.size() != 0) @(posedge aclk);
            end
            row.typed = 0;
            row.exp   = res_of(0, 1, 0, 0);
            row.cmd   = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, 5));
            row.an = rand_opnd();
            row.ad = rand_opnd();
            row.bn = rand_opnd();
            row.bd = rand_opnd();
            // Steer some equality tests toward scaled copies of A.
            if (row.cmd == CMD_EQ && $urandom_range(0, 2) == 0) begin
                row.an = shortint'(int'($urandom_range(0, 200)) - 100);
                row.ad = shortint'(int'($urandom_range(0, 200)) - 100);
                row.bn = shortint'(row.an * 3);
                row.bd = shortint'(row.ad * 3);
            end
            send_item(row);
        end
        calm = 0;
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("Covered %0d items and %0d results: %0d zero-denominator, %0d equal.",
                 n_sent, n_got, n_divz, n_eq);
        $display("All six commands, unused codes, extremes and a long output hold-off ran.");
        if (n_fail == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/rar_pkg.sv
src/rar_dp.sv
src/rar_ctrl.sv
src/rational_arith_reduce_top.sv
verif/tb_top.sv
